@@ hdl/graph_adjacency_engine_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the graph adjacency engine
// Shared forms of clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GRAPH_ADJACENCY_ENGINE_DEFINES_SVH
`define GRAPH_ADJACENCY_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GAE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GAE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/gae_pkg.sv @@
// ----------------------------------------------------------------------------
// Graph adjacency engine package
// Operation codes, sequencer states and the row memory request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gae_pkg;

	localparam int VERTEX_W = 6;
	localparam int OP_W     = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_EDGE    = 3'd0,
		OP_REMOVE_EDGE = 3'd1,
		OP_TEST_EDGE   = 3'd2,
		OP_CLEAR_VERT  = 3'd3,
		OP_COMMON      = 3'd4
	} gae_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_A,
		ST_WR_B,
		ST_TEST,
		ST_LOAD,
		ST_EMIT,
		ST_CLEAR,
		ST_RESULT
	} gae_state_t;

	// One request per cycle to the row memory: a paired read and a single write.
	typedef struct packed {
		logic                rd_en;
		logic [VERTEX_W-1:0] rd_addr_a;
		logic [VERTEX_W-1:0] rd_addr_b;
		logic                wr_en;
		logic [VERTEX_W-1:0] wr_addr;
	} gae_mem_req_t;

endpackage

`default_nettype wire

@@ hdl/gae_row_mem.sv @@
// ----------------------------------------------------------------------------
// Adjacency row memory
// One row per vertex, two registered read ports and one write port. A row
// that was never written since reset reads as all zeros through its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gae_row_mem
	import gae_pkg::*;
#(
	parameter int NUM_VERTICES = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire gae_mem_req_t            req,
	input  wire logic [NUM_VERTICES-1:0] wr_data,
	output logic      [NUM_VERTICES-1:0] rd_data_a,
	output logic      [NUM_VERTICES-1:0] rd_data_b
);

	localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

	logic [NUM_VERTICES-1:0] mem [NUM_VERTICES];
	logic [NUM_VERTICES-1:0] row_valid_q;
	logic [NUM_VERTICES-1:0] rdata_a_q;
	logic [NUM_VERTICES-1:0] rdata_b_q;
	logic                    rvalid_a_q;
	logic                    rvalid_b_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata_a_q <= mem[req.rd_addr_a[AW-1:0]];
			rdata_b_q <= mem[req.rd_addr_b[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_a_q  <= 1'b0;
			rvalid_b_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_a_q <= row_valid_q[req.rd_addr_a[AW-1:0]];
				rvalid_b_q <= row_valid_q[req.rd_addr_b[AW-1:0]];
			end
		end
	end

	assign rd_data_a = rvalid_a_q ? rdata_a_q : '0;
	assign rd_data_b = rvalid_b_q ? rdata_b_q : '0;

endmodule

`default_nettype wire

@@ hdl/graph_adjacency_engine.sv @@
// ----------------------------------------------------------------------------
// Graph adjacency engine
// Undirected graph held as a symmetric adjacency bit matrix in a row memory.
// Adds, removes and tests edges, clears a vertex and lists common neighbours.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_*       in         op, first_vertex, second_vertex (one operation)
//  m_*       out        edge_present, neighbour, neighbour_valid, last
//
//  Add and remove edge read both rows, then write row a and then row b; test edge
//  reads both rows and tests the bit; common neighbours reads both rows, then emits
//  one beat per common neighbour (at least one beat). Undefined codes, and add,
//  remove or clear on a vertex out of range, go straight to the result. Edges take
//  two writes as the row memory has a single write port; the clear walk reads and
//  writes one row per cycle, then makes the last write and leaves the walk.
//  One operation is in work at a time; a finished result waits in the output
//  register while the next beat is taken. Reset leaves the graph empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_adjacency_engine_defines.svh"

module graph_adjacency_engine
	import gae_pkg::*;
#(
	parameter int NUM_VERTICES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // op[2:0], first_vertex[8:3], second_vertex[14:9]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // edge_present[0], neighbour[6:1]
	output logic             m_tuser,  // neighbour_valid[0]
	output logic             m_tlast
);

	localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int CW = $clog2(NUM_VERTICES + 1);

	gae_state_t              state_q, state_d;
	gae_op_t                 op_q;
	logic [VERTEX_W-1:0]     a_q, b_q;
	logic                    present_q, present_d, present_ld;
	logic [NUM_VERTICES-1:0] common_q, common_d;
	logic                    common_ld;
	logic [CW-1:0]           rd_cnt_q;
	logic                    cnt_clr, rd_issue;
	logic                    wr_pend_s1;
	logic [AW-1:0]           wr_row_s1;

	logic                    m_tvalid_q, ep_q, nv_q, last_q;
	logic [VERTEX_W-1:0]     nb_q;

	gae_op_t                 in_op;
	logic [VERTEX_W-1:0]     in_a, in_b;
	logic                    in_a_ok, in_ab_ok, a_ok, ab_ok;
	logic                    s_accept, out_free, push;
	logic                    res_ep, res_nv, res_last;
	logic [VERTEX_W-1:0]     res_nb;

	gae_mem_req_t            mem_req;
	logic [NUM_VERTICES-1:0] wr_data, rd_data_a, rd_data_b;
	logic [NUM_VERTICES-1:0] bit_a, bit_b, low_bit, rest;
	logic [AW-1:0]           low_idx;
	logic                    rw_both;

	gae_row_mem #(
		.NUM_VERTICES(NUM_VERTICES)
	) u_row_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.wr_data  (wr_data),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	assign in_op    = gae_op_t'(s_tdata[2:0]);
	assign in_a     = s_tdata[8:3];
	assign in_b     = s_tdata[14:9];
	assign in_a_ok  = (32'(in_a) < NUM_VERTICES);
	assign in_ab_ok = in_a_ok && (32'(in_b) < NUM_VERTICES);
	assign a_ok     = (32'(a_q) < NUM_VERTICES);
	assign ab_ok    = a_ok && (32'(b_q) < NUM_VERTICES);

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign bit_a = {{(NUM_VERTICES-1){1'b0}}, 1'b1} << a_q[AW-1:0];
	assign bit_b = {{(NUM_VERTICES-1){1'b0}}, 1'b1} << b_q[AW-1:0];

	// Lowest remaining common neighbour: isolate the lowest set bit, then encode it.
	assign low_bit = common_q & (~common_q + {{(NUM_VERTICES-1){1'b0}}, 1'b1});
	assign rest    = common_q & ~low_bit;

	always_comb begin
		low_idx = '0;
		for (int j = 0; j < NUM_VERTICES; j++) begin
			if (low_bit[j]) begin
				low_idx = low_idx | AW'(j);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_req    = '0;
		wr_data    = '0;
		push       = 1'b0;
		res_ep     = 1'b0;
		res_nb     = '0;
		res_nv     = 1'b0;
		res_last   = 1'b1;
		present_ld = 1'b0;
		present_d  = 1'b0;
		common_ld  = 1'b0;
		common_d   = '0;
		cnt_clr    = 1'b0;
		rd_issue   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					mem_req.rd_en     = 1'b1;
					mem_req.rd_addr_a = in_a;
					mem_req.rd_addr_b = in_b;
					present_ld        = 1'b1;
					cnt_clr           = 1'b1;
					unique case (in_op)
						OP_ADD_EDGE, OP_REMOVE_EDGE: begin
							state_d = in_ab_ok ? ST_WR_A : ST_RESULT;
						end
						OP_TEST_EDGE:  state_d = ST_TEST;
						OP_CLEAR_VERT: state_d = in_a_ok ? ST_CLEAR : ST_RESULT;
						OP_COMMON:     state_d = ST_LOAD;
						default:       state_d = ST_RESULT;
					endcase
				end
			end
			ST_WR_A: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = a_q;
				wr_data = (op_q == OP_ADD_EDGE) ? (rd_data_a | bit_b) : (rd_data_a & ~bit_b);
				state_d = ST_WR_B;
			end
			ST_WR_B: begin
				// Row b still holds its pre-update contents, which is also right when a equals b.
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = b_q;
				wr_data = (op_q == OP_ADD_EDGE) ? (rd_data_b | bit_a) : (rd_data_b & ~bit_a);
				state_d = ST_RESULT;
			end
			ST_TEST: begin
				present_ld = 1'b1;
				present_d  = ab_ok && rd_data_a[b_q[AW-1:0]];
				state_d    = ST_RESULT;
			end
			ST_LOAD: begin
				common_ld = 1'b1;
				common_d  = ab_ok ? (rd_data_a & rd_data_b) : '0;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					push      = 1'b1;
					res_nb    = VERTEX_W'(low_idx);
					res_nv    = |common_q;
					res_last  = (rest == '0);
					common_ld = 1'b1;
					common_d  = rest;
					if (rest == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CLEAR: begin
				// Read row r while row r-1 is written back without bit a, or as all zeros if it is row a.
				rd_issue          = (rd_cnt_q < CW'(NUM_VERTICES));
				mem_req.rd_en     = rd_issue;
				mem_req.rd_addr_a = VERTEX_W'(rd_cnt_q[AW-1:0]);
				mem_req.rd_addr_b = VERTEX_W'(rd_cnt_q[AW-1:0]);
				if (wr_pend_s1) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = VERTEX_W'(wr_row_s1);
					wr_data = (wr_row_s1 == a_q[AW-1:0]) ? '0 : (rd_data_a & ~bit_a);
				end
				if (!rd_issue && !wr_pend_s1) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					push    = 1'b1;
					res_ep  = present_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_cnt_q   <= '0;
			wr_pend_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_pend_s1 <= rd_issue;
			if (cnt_clr) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q <= in_op;
			a_q  <= in_a;
			b_q  <= in_b;
		end
		if (present_ld) begin
			present_q <= present_d;
		end
		if (common_ld) begin
			common_q <= common_d;
		end
		wr_row_s1 <= rd_cnt_q[AW-1:0];
		if (push) begin
			ep_q   <= res_ep;
			nb_q   <= res_nb;
			nv_q   <= res_nv;
			last_q <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, nb_q, ep_q};
	assign m_tuser  = nv_q;
	assign m_tlast  = last_q;

	assign rw_both = mem_req.wr_en && mem_req.rd_en;

	`GAE_ASSERT_NOW(a_no_idle_write, state_q == ST_IDLE, !mem_req.wr_en, "row write while idle")
	`GAE_ASSERT_NOW(a_rw_apart, rw_both, mem_req.wr_addr != mem_req.rd_addr_a, "row read and written")
	`GAE_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready, "second beat taken while busy")
	`GAE_ASSERT_NEXT(a_idle_after_last, push && res_last, state_q == ST_IDLE, "last beat, not idle")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graph adjacency engine testbench
// Drives operation beats into the engine and checks every result beat against a
// local model of the adjacency matrix or a typed beat of the directed table, which
// comes first; then random episodes: dense clusters, full fans, teardown and noise.
// ----------------------------------------------------------------------------

module testbench
	import gae_pkg::*;
();

	localparam int NUM_VERTICES   = 64;
	localparam int N_DIRECTED     = 25;
	localparam int TOTAL_ITEMS    = 410;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = NUM_VERTICES + 8;
	localparam int LONG_HOLD      = 250;

	// Codes outside the defined operation set.
	localparam logic [2:0] OP_RSVD_5 = 3'd5;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	typedef struct packed {
		logic       present;
		logic [5:0] nb;
		logic       nb_valid;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [2:0] op;
		logic [5:0] first_v;
		logic [5:0] second_v;
		logic       typed;
		result_t    beat;
	} row_t;

	localparam result_t R_ACK     = '{1'b0, 6'd0, 1'b0, 1'b1};
	localparam result_t R_PRESENT = '{1'b1, 6'd0, 1'b0, 1'b1};
	localparam result_t R_ANY     = '{1'b0, 6'd0, 1'b0, 1'b0};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic [63:0] graph_rows [NUM_VERTICES];
	result_t     predicted_beats [$];
	result_t     pending_beats [$];

	int  failures;
	int  items_sent;
	int  results_seen;
	int  idle_cycles;
	int  longest_list;
	int  op_counts [8];
	bit  sender_burst;

	row_t directed_rows [N_DIRECTED] = '{
		'{OP_TEST_EDGE,   6'd0,  6'd0,  1'b1, R_ACK},
		'{OP_COMMON,      6'd0,  6'd63, 1'b1, R_ACK},
		'{OP_ADD_EDGE,    6'd0,  6'd63, 1'b1, R_ACK},
		'{OP_TEST_EDGE,   6'd63, 6'd0,  1'b1, R_PRESENT},
		'{OP_TEST_EDGE,   6'd0,  6'd62, 1'b1, R_ACK},
		'{OP_ADD_EDGE,    6'd5,  6'd5,  1'b1, R_ACK},
		'{OP_TEST_EDGE,   6'd5,  6'd5,  1'b1, R_PRESENT},
		'{OP_ADD_EDGE,    6'd5,  6'd6,  1'b1, R_ACK},
		'{OP_ADD_EDGE,    6'd6,  6'd7,  1'b1, R_ACK},
		'{OP_ADD_EDGE,    6'd7,  6'd5,  1'b1, R_ACK},
		'{OP_COMMON,      6'd5,  6'd6,  1'b0, R_ANY},
		'{OP_COMMON,      6'd6,  6'd7,  1'b1, '{1'b0, 6'd5, 1'b1, 1'b1}},
		'{OP_ADD_EDGE,    6'd0,  6'd5,  1'b1, R_ACK},
		'{OP_ADD_EDGE,    6'd63, 6'd5,  1'b1, R_ACK},
		'{OP_COMMON,      6'd0,  6'd63, 1'b1, '{1'b0, 6'd5, 1'b1, 1'b1}},
		'{OP_COMMON,      6'd5,  6'd5,  1'b0, R_ANY},
		'{OP_REMOVE_EDGE, 6'd63, 6'd0,  1'b1, R_ACK},
		'{OP_TEST_EDGE,   6'd0,  6'd63, 1'b1, R_ACK},
		'{OP_CLEAR_VERT,  6'd5,  6'd63, 1'b1, R_ACK},
		'{OP_TEST_EDGE,   6'd5,  6'd5,  1'b1, R_ACK},
		'{OP_COMMON,      6'd6,  6'd7,  1'b1, R_ACK},
		'{OP_TEST_EDGE,   6'd6,  6'd7,  1'b1, R_PRESENT},
		'{OP_RSVD_5,      6'd63, 6'd63, 1'b1, R_ACK},
		'{OP_RSVD_6,      6'd0,  6'd0,  1'b1, R_ACK},
		'{OP_RSVD_7,      6'd42, 6'd21, 1'b1, R_ACK}
	};

	graph_adjacency_engine #(
		.NUM_VERTICES(NUM_VERTICES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one operation to the local graph and leaves its result beats
	// in predicted_beats.
	function automatic void apply_graph_op(input logic [2:0] op, input logic [5:0] a,
			input logic [5:0] b);
		logic [63:0] common;
		logic        present;
		bit          a_ok;
		bit          b_ok;
		predicted_beats.delete();
		a_ok = a < NUM_VERTICES;
		b_ok = b < NUM_VERTICES;
		common = '0;
		present = 1'b0;
		case (op)
			OP_ADD_EDGE: begin
				if (a_ok && b_ok) begin
					graph_rows[a][b] = 1'b1;
					graph_rows[b][a] = 1'b1;
				end
			end
			OP_REMOVE_EDGE: begin
				if (a_ok && b_ok) begin
					graph_rows[a][b] = 1'b0;
					graph_rows[b][a] = 1'b0;
				end
			end
			OP_TEST_EDGE: begin
				if (a_ok && b_ok)
					present = graph_rows[a][b];
			end
			OP_CLEAR_VERT: begin
				if (a_ok) begin
					for (int r = 0; r < NUM_VERTICES; r++)
						graph_rows[r][a] = 1'b0;
					graph_rows[a] = '0;
				end
			end
			OP_COMMON: begin
				if (a_ok && b_ok)
					common = graph_rows[a] & graph_rows[b];
				for (int u = 0; u < 64; u++)
					if (common[u])
						predicted_beats.insert(predicted_beats.size(),
							'{1'b0, 6'(u), 1'b1, 1'b0});
			end
			default: ;
		endcase
		// A neighbour list marks its final entry; everything else is one beat.
		if (predicted_beats.size() != 0)
			predicted_beats[$].last = 1'b1;
		else
			predicted_beats.insert(0, '{present, 6'd0, 1'b0, 1'b1});
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_op(input logic [2:0] op, input logic [5:0] a, input logic [5:0] b,
			input logic typed, input result_t typed_beat);
		int gap;
		gap = sender_burst ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, b, a, op};
		do @(posedge clk); while (!s_tready);
		apply_graph_op(op, a, b);
		if (predicted_beats.size() > longest_list)
			longest_list = predicted_beats.size();
		if (typed)
			pending_beats.insert(pending_beats.size(), typed_beat);
		else
			foreach (predicted_beats[k])
				pending_beats.insert(pending_beats.size(), predicted_beats[k]);
		op_counts[op]++;
		items_sent++;
	endtask

	// Result checker and watchdog.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d idle cycles, %0d beats outstanding",
					idle_cycles, pending_beats.size());
				$display("CHECKS FAILED");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_beats.size() == 0) begin
					$error("Unexpected result beat: tdata=%h tuser=%b tlast=%b",
						m_tdata, m_tuser, m_tlast);
					failures++;
				end else begin
					want = pending_beats.pop_front();
					if (m_tdata[0] !== want.present) begin
						$error("edge_present: expected %0d, got %0d", want.present, m_tdata[0]);
						failures++;
					end
					if (m_tdata[6:1] !== want.nb) begin
						$error("neighbour: expected %0d, got %0d", want.nb, m_tdata[6:1]);
						failures++;
					end
					if (m_tuser !== want.nb_valid) begin
						$error("neighbour_valid: expected %0d, got %0d", want.nb_valid, m_tuser);
						failures++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						failures++;
					end
				end
			end
		end
	end

	// Result consumer: random stalls, long open stretches, and one long
	// hold-off that backs the engine up into its input.
	initial begin : receiver
		int  hold;
		int  run;
		bit  long_hold_done;
		long_hold_done = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && results_seen >= 60) begin
				long_hold_done = 1'b1;
				hold = LONG_HOLD;
				run  = $urandom_range(1, 8);
			end else if ($urandom_range(0, 9) == 0) begin
				hold = 0;
				run  = $urandom_range(100, 300);
			end else begin
				hold = pick_gap();
				run  = $urandom_range(1, 12);
			end
			repeat (hold) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			repeat (run) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [5:0] cluster [8];
		logic [5:0] perm [64];
		logic [5:0] swap;
		logic [5:0] hub;
		int         k;
		int         j;
		int         episode;
		bit         fan_done;
		bit         drained;

		failures = 0;
		items_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		longest_list = 0;
		sender_burst = 1'b0;
		fan_done = 1'b0;
		drained = 1'b0;
		foreach (op_counts[i])
			op_counts[i] = 0;
		foreach (graph_rows[i])
			graph_rows[i] = '0;
		foreach (cluster[i])
			cluster[i] = 6'(i);
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_op(directed_rows[i].op, directed_rows[i].first_v, directed_rows[i].second_v,
				directed_rows[i].typed, directed_rows[i].beat);

		k = 3;
		while (items_sent < TOTAL_ITEMS) begin
			sender_burst = ($urandom_range(0, 3) == 0);
			// Once, let the engine run dry before going on.
			if (!drained && items_sent >= 200) begin
				drained = 1'b1;
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (pending_beats.size() != 0)
					@(posedge clk);
			end
			episode = fan_done ? $urandom_range(0, 99) : 99;
			if (episode >= 96) begin
				// Full fan on one vertex, self-loop included, then list it
				// against itself for the longest possible neighbour list.
				fan_done = 1'b1;
				hub = 6'($urandom_range(0, NUM_VERTICES - 1));
				foreach (perm[i])
					perm[i] = 6'(i);
				for (int i = 63; i > 0; i--) begin
					j = $urandom_range(0, i);
					swap = perm[i];
					perm[i] = perm[j];
					perm[j] = swap;
				end
				foreach (perm[i])
					send_op(OP_ADD_EDGE, hub, perm[i], 1'b0, R_ANY);
				send_op(OP_COMMON, hub, hub, 1'b0, R_ANY);
				send_op(OP_COMMON, 6'($urandom_range(0, 63)), hub, 1'b0, R_ANY);
				send_op(OP_CLEAR_VERT, hub, 6'($urandom_range(0, 63)), 1'b0, R_ANY);
				send_op(OP_COMMON, hub, hub, 1'b0, R_ANY);
			end else if (episode < 50) begin
				// Dense cluster: many edges among a few vertices, then queries.
				k = $urandom_range(3, 8);
				for (int i = 0; i < k; i++)
					cluster[i] = 6'($urandom_range(0, 63));
				repeat ($urandom_range(k, 3 * k))
					send_op(OP_ADD_EDGE, cluster[$urandom_range(0, k - 1)],
						cluster[$urandom_range(0, k - 1)], 1'b0, R_ANY);
				repeat ($urandom_range(2, 5))
					send_op(OP_COMMON, cluster[$urandom_range(0, k - 1)],
						cluster[$urandom_range(0, k - 1)], 1'b0, R_ANY);
				send_op(OP_TEST_EDGE, cluster[$urandom_range(0, k - 1)],
					cluster[$urandom_range(0, k - 1)], 1'b0, R_ANY);
			end else if (episode < 75) begin
				// Unstructured beats over the whole code and vertex space.
				repeat ($urandom_range(5, 15))
					send_op(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
						6'($urandom_range(0, 63)), 1'b0, R_ANY);
			end else begin
				// Tear down part of the last cluster and look again.
				repeat ($urandom_range(1, 4))
					send_op(OP_REMOVE_EDGE, cluster[$urandom_range(0, k - 1)],
						cluster[$urandom_range(0, k - 1)], 1'b0, R_ANY);
				send_op(OP_COMMON, cluster[$urandom_range(0, k - 1)],
					cluster[$urandom_range(0, k - 1)], 1'b0, R_ANY);
				send_op(OP_CLEAR_VERT, cluster[$urandom_range(0, k - 1)],
					6'($urandom_range(0, 63)), 1'b0, R_ANY);
				repeat ($urandom_range(1, 3))
					send_op(OP_COMMON, cluster[$urandom_range(0, k - 1)],
						cluster[$urandom_range(0, k - 1)], 1'b0, R_ANY);
				send_op(OP_TEST_EDGE, cluster[$urandom_range(0, k - 1)],
					cluster[$urandom_range(0, k - 1)], 1'b0, R_ANY);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d operations (add %0d, remove %0d, test %0d, clear %0d, common %0d,",
			items_sent, op_counts[OP_ADD_EDGE], op_counts[OP_REMOVE_EDGE],
			op_counts[OP_TEST_EDGE], op_counts[OP_CLEAR_VERT], op_counts[OP_COMMON]);
		$display("undefined %0d); checked %0d result beats, longest neighbour list %0d.",
			op_counts[OP_RSVD_5] + op_counts[OP_RSVD_6] + op_counts[OP_RSVD_7],
			results_seen, longest_list);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/gae_pkg.sv
hdl/gae_row_mem.sv
hdl/graph_adjacency_engine.sv
bench/testbench.sv
